### rtl/ufrc_pkg.sv
`timescale 1ns / 1ps

package ufrc_pkg;

  localparam int MAX_FRAME_BYTES_DEFAULT = 2048;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  VERSION_IHL    = 8'h45;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [15:0] SUM_GOOD       = 16'hFFFF;
  localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;

  // frame offsets
  localparam int OFS_TYPE_LO   = 13;
  localparam int OFS_VERSION   = 14;
  localparam int OFS_PROTO     = 23;
  localparam int OFS_SRC_IP    = 26;
  localparam int OFS_SRC_IP_LO = 29;
  localparam int OFS_DST_IP    = 30;
  localparam int OFS_IP_END    = 33;
  localparam int OFS_UDP       = 34;
  localparam int OFS_PORTS_LO  = 37;
  localparam int OFS_LEN       = 38;
  localparam int OFS_LEN_LO    = 39;
  localparam int MIN_FRAME     = 40;

  localparam logic [2:0] REASON_OK      = 3'd0;
  localparam logic [2:0] REASON_TYPE    = 3'd1;
  localparam logic [2:0] REASON_VERSION = 3'd2;
  localparam logic [2:0] REASON_PROTO   = 3'd3;
  localparam logic [2:0] REASON_IPSUM   = 3'd4;
  localparam logic [2:0] REASON_UDPSUM  = 3'd5;
  localparam logic [2:0] REASON_SHORT   = 3'd6;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } ufrc_in_t;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  reason;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [15:0] payload_length;
  } ufrc_out_t;

  // ones' complement add with end-around carry
  function automatic logic [15:0] csum_add(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

### rtl/udp_frame_receive_checker.sv
`timescale 1ns / 1ps

// result path: a last beat goes from the input register into the result register,
// which loads once any previous result held there has been taken
// throughput: one beat per cycle; a last beat waits only while a previous
// result is still held in the result register
// reset: synchronous, clears both valid flags and all per-frame state

module udp_frame_receive_checker #(
  parameter int MaxFrameBytes = ufrc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                frame_valid,
  output logic                frame_ready,
  input  ufrc_pkg::ufrc_in_t  frame,
  output logic                result_valid,
  input  logic                result_ready,
  output ufrc_pkg::ufrc_out_t result
);
  import ufrc_pkg::*;

  logic      s1_valid;
  ufrc_in_t  s1_beat;
  logic      step;
  ufrc_out_t core_res;

  // a non-last beat never needs the result register
  assign step        = s1_valid && (!s1_beat.last_byte || !result_valid || result_ready);
  assign frame_ready = !s1_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame_ready) begin
      s1_valid <= frame_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      s1_beat <= frame;
    end
  end

  ufrc_core #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .step(step),
    .beat(s1_beat),
    .res (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && s1_beat.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && s1_beat.last_byte) begin
      result <= core_res;
    end
  end

`ifndef SYNTHESIS
  a_last_loads_result: assert property (@(posedge clk) disable iff (rst)
    (step && s1_beat.last_byte) |=> result_valid)
    else $error("last beat did not produce a result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_beat.last_byte && result_valid && !result_ready) |-> !frame_ready)
    else $error("last beat advanced over a held result");

  a_accept_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.accepted == (result.reason == REASON_OK)))
    else $error("accept flag disagrees with reason");

  a_reject_len: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.accepted) |-> (result.payload_length == 16'd0))
    else $error("rejected frame carries a payload length");
`endif

endmodule

### rtl/ufrc_core.sv
`timescale 1ns / 1ps

module ufrc_core #(
  parameter int MaxFrameBytes = ufrc_pkg::MAX_FRAME_BYTES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ufrc_pkg::ufrc_in_t  beat,
  output ufrc_pkg::ufrc_out_t res
);
  import ufrc_pkg::*;

  localparam int PW = $clog2(MaxFrameBytes + 1);
  localparam int CW = ((PW > 16) ? PW : 16) + 2;

  logic [PW-1:0] pos, pos_next;
  logic [15:0]   ip_sum, ip_sum_next;
  logic [15:0]   udp_sum, udp_sum_next;
  logic [7:0]    held, held_next;
  logic [2:0]    fault, fault_next;
  logic [31:0]   src_ip, src_ip_next;
  logic [31:0]   dst_ip, dst_ip_next;
  logic [31:0]   ports, ports_next;
  logic [15:0]   udp_len, udp_len_next;

  logic [7:0]    b;
  logic [15:0]   word;
  logic          odd;
  logic          in_range;
  logic          summed;
  logic [PW-1:0] off;
  logic [2:0]    step_fault;
  logic          short_frame;
  logic [15:0]   udp_final;
  logic [2:0]    reason;

  always_comb begin
    b        = beat.frame_byte;
    word     = {held, b};
    odd      = pos[0];
    in_range = pos < PW'(MaxFrameBytes);
    off      = pos - PW'(OFS_UDP);
    summed   = (pos < PW'(OFS_UDP)) || (off < PW'(8)) || (CW'(off) < CW'(udp_len));

    pos_next     = pos;
    ip_sum_next  = ip_sum;
    udp_sum_next = udp_sum;
    held_next    = held;
    src_ip_next  = src_ip;
    dst_ip_next  = dst_ip;
    ports_next   = ports;
    udp_len_next = udp_len;
    step_fault   = REASON_OK;

    if (!in_range) begin
      // oversize frame: byte dropped, count saturates
      step_fault = REASON_SHORT;
    end else begin
      pos_next = pos + PW'(1);
      if (pos == PW'(OFS_TYPE_LO) && word != ETHERTYPE_IPV4) step_fault = REASON_TYPE;
      if (pos == PW'(OFS_VERSION) && b != VERSION_IHL) step_fault = REASON_VERSION;
      if (pos == PW'(OFS_PROTO) && b != PROTO_UDP) step_fault = REASON_PROTO;

      if (pos >= PW'(OFS_VERSION) && pos <= PW'(OFS_IP_END) && odd) begin
        ip_sum_next = csum_add(ip_sum, word);
      end
      if (pos == PW'(OFS_IP_END) && ip_sum_next != SUM_GOOD) step_fault = REASON_IPSUM;

      // addresses go into the pseudo-header sum
      if (pos >= PW'(OFS_SRC_IP) && pos <= PW'(OFS_IP_END) && odd) begin
        udp_sum_next = csum_add(udp_sum, word);
      end
      if (pos >= PW'(OFS_SRC_IP) && pos <= PW'(OFS_SRC_IP_LO)) src_ip_next = {src_ip[23:0], b};
      if (pos >= PW'(OFS_DST_IP) && pos <= PW'(OFS_IP_END)) dst_ip_next = {dst_ip[23:0], b};
      if (pos >= PW'(OFS_UDP) && pos <= PW'(OFS_PORTS_LO)) ports_next = {ports[23:0], b};
      if (pos >= PW'(OFS_LEN) && pos <= PW'(OFS_LEN_LO)) udp_len_next = {udp_len[7:0], b};

      if (pos >= PW'(OFS_UDP)) begin
        if (summed && odd) udp_sum_next = csum_add(udp_sum, word);
        if (pos == PW'(OFS_LEN_LO)) begin
          udp_sum_next = csum_add(csum_add(udp_sum_next, {8'd0, PROTO_UDP}), udp_len_next);
          if (udp_len_next < UDP_HDR_BYTES) step_fault = REASON_SHORT;
        end
      end
      if (!odd && summed) held_next = b;
    end

    fault_next = (fault == REASON_OK) ? step_fault : fault;

    short_frame = (CW'(pos_next) < CW'(MIN_FRAME)) ||
                  (CW'(pos_next) < CW'(OFS_UDP) + CW'(udp_len_next));
    // odd length: pad the last byte with zero
    udp_final = udp_len_next[0] ? csum_add(udp_sum_next, {held_next, 8'd0}) : udp_sum_next;

    if (fault_next != REASON_OK) begin
      reason = fault_next;
    end else if (short_frame) begin
      reason = REASON_SHORT;
    end else if (udp_final == SUM_GOOD) begin
      reason = REASON_OK;
    end else begin
      reason = REASON_UDPSUM;
    end

    res.accepted       = (reason == REASON_OK);
    res.reason         = reason;
    res.source_ip      = src_ip_next;
    res.dest_ip        = dst_ip_next;
    res.source_port    = ports_next[31:16];
    res.dest_port      = ports_next[15:0];
    res.payload_length = (reason == REASON_OK) ? (udp_len_next - UDP_HDR_BYTES) : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && beat.last_byte)) begin
      pos     <= '0;
      ip_sum  <= '0;
      udp_sum <= '0;
      held    <= '0;
      fault   <= REASON_OK;
      src_ip  <= '0;
      dst_ip  <= '0;
      ports   <= '0;
      udp_len <= '0;
    end else if (step) begin
      pos     <= pos_next;
      ip_sum  <= ip_sum_next;
      udp_sum <= udp_sum_next;
      held    <= held_next;
      fault   <= fault_next;
      src_ip  <= src_ip_next;
      dst_ip  <= dst_ip_next;
      ports   <= ports_next;
      udp_len <= udp_len_next;
    end
  end

`ifndef SYNTHESIS
  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    pos <= PW'(MaxFrameBytes))
    else $error("byte count beyond frame limit");

  a_fault_sticky: assert property (@(posedge clk) disable iff (rst)
    (step && !beat.last_byte && fault != REASON_OK) |=> $stable(fault))
    else $error("first fault code overwritten");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    (step && beat.last_byte) |=> (pos == '0 && fault == REASON_OK))
    else $error("frame state not cleared after last beat");
`endif

endmodule
